// ===== hw/rtl/byte_ring_queue_multibyte_assert.svh =====
// Assertion macros for the byte ring queue checker.
// Included by brq_checker.sv; no other dependencies.
`ifndef BYTE_RING_QUEUE_MULTIBYTE_ASSERT_SVH
`define BYTE_RING_QUEUE_MULTIBYTE_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define BRQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("brq assertion failed");

// Clocked check that also holds through reset.
`define BRQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("brq assertion failed");

`endif

// ===== hw/rtl/brq_pkg.sv =====
// Shared types and constants for the multi-byte ring queue.
// No dependencies.
package brq_pkg;

    localparam int CAP_W          = 9;
    localparam int NB_W           = 4;
    localparam int DATA_W         = 64;
    localparam int LEVEL_W        = 8;
    localparam int STAT_W         = 2;
    localparam int DEF_STORE_DEPTH = 256;
    localparam int DEF_MAX_ELEM   = 8;
    localparam int CMDQ_DEPTH     = 2;
    localparam int CMDQ_PW        = $clog2(CMDQ_DEPTH);

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [DATA_W-1:0] EMPTY_MARK = 64'hFF;

    // Classified request handed from front to back.
    typedef struct packed {
        logic              op;
        logic [NB_W-1:0]   nbytes;   // zero when refused
        logic [DATA_W-1:0] data;
        logic [STAT_W-1:0] status;
        logic [LEVEL_W-1:0] level;
    } t_cmd;

endpackage

// ===== hw/rtl/brq_front.sv =====
// Front end: takes requests, checks them against the fill count, queues commands.
// Depends on brq_pkg.
module brq_front
    import brq_pkg::*;
#(
    parameter int MAX_ELEMENT_BYTES = DEF_MAX_ELEM
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_clear,
    input  logic [CAP_W-1:0]  i_capacity,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_operation,
    input  logic [NB_W-1:0]   i_element_bytes,
    input  logic [DATA_W-1:0] i_put_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_cmd              o_q_cmd
);

    localparam logic [NB_W-1:0] MAX_NB = NB_W'(MAX_ELEMENT_BYTES);

    logic [CAP_W-1:0] r_fill;
    logic [CAP_W-1:0] n_fill;
    logic [NB_W-1:0]  nb;
    logic [CAP_W:0]   put_sum;
    logic             take;
    logic             accept;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign o_q_push   = accept;

    always_comb begin
        nb      = (i_element_bytes > MAX_NB) ? MAX_NB : i_element_bytes;
        put_sum = {1'b0, r_fill} + (CAP_W+1)'(nb);
        if (i_operation == OP_PUT) begin
            take   = put_sum < {1'b0, i_capacity};
            n_fill = take ? put_sum[CAP_W-1:0] : r_fill;
        end else begin
            take   = r_fill >= CAP_W'(nb);
            n_fill = take ? (r_fill - CAP_W'(nb)) : r_fill;
        end

        o_q_cmd.op     = i_operation;
        o_q_cmd.nbytes = take ? nb : '0;
        o_q_cmd.data   = i_put_data;
        if (take) begin
            o_q_cmd.status = ST_OK;
        end else if (i_operation == OP_PUT) begin
            o_q_cmd.status = ST_FULL;
        end else begin
            o_q_cmd.status = ST_EMPTY;
        end
        o_q_cmd.level = (n_fill > CAP_W'(255)) ? 8'hFF : n_fill[LEVEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_clear) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

endmodule

// ===== hw/rtl/brq_cmd_fifo.sv =====
// Two-entry command queue between front and back end.
// Depends on brq_pkg.
module brq_cmd_fifo
    import brq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                 r_slot [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0]   r_wp;
    logic [CMDQ_PW-1:0]   r_rp;
    logic [CMDQ_PW:0]     r_cnt;

    assign o_full  = r_cnt == (CMDQ_PW+1)'(CMDQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/brq_back.sv =====
// Back end: moves bytes through the single-port byte store and drives results.
// Depends on brq_pkg.
module brq_back
    import brq_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_clear,
    input  logic [CAP_W-1:0]   i_capacity,
    input  logic               i_q_empty,
    input  t_cmd               i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [DATA_W-1:0]  o_get_data,
    output logic [LEVEL_W-1:0] o_fill_level
);

    // capacity never exceeds 511, so entries past that are unreachable
    localparam int MEM_DEPTH = (STORE_DEPTH < 512) ? STORE_DEPTH : 512;
    localparam int IW        = $clog2(MEM_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_XFER = 3'b010,
        S_FIN  = 3'b100
    } t_bstate;

    t_bstate           r_state;
    t_cmd              r_cmd;
    logic [NB_W-1:0]   r_cnt;
    logic [IW-1:0]     r_wr_idx;
    logic [IW-1:0]     r_rd_idx;
    logic [DATA_W-1:0] r_gdata;
    logic              r_rd_v;
    logic [2:0]        r_rd_slot;
    logic [7:0]        r_mem_rdata;
    logic [7:0]        mem [MEM_DEPTH];

    logic              out_free;
    logic              is_put;
    logic [IW-1:0]     addr;
    logic [IW-1:0]     n_idx;
    logic [CAP_W:0]    idx_inc;
    logic              mem_we;
    logic [7:0]        wbyte;

    assign out_free = !o_out_valid || !i_out_stall;
    assign is_put   = r_cmd.op == OP_PUT;
    assign addr     = is_put ? r_wr_idx : r_rd_idx;
    assign mem_we   = (r_state == S_XFER) && is_put;
    assign wbyte    = r_cmd.data[{r_cnt[2:0], 3'b000} +: 8];
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;

    // wrap at the configured capacity
    always_comb begin
        idx_inc = (CAP_W+1)'(addr) + (CAP_W+1)'(1);
        n_idx   = (idx_inc >= {1'b0, i_capacity}) ? '0 : IW'(idx_inc);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr] <= wbyte;
        end
        r_mem_rdata <= mem[addr];
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd   <= i_q_cmd;
            r_gdata <= (i_q_cmd.status == ST_EMPTY) ? EMPTY_MARK : '0;
        end else if (r_rd_v) begin
            r_gdata[{r_rd_slot, 3'b000} +: 8] <= r_mem_rdata;
        end
        r_rd_slot <= r_cnt[2:0];
        if ((r_state == S_FIN) && !r_rd_v && out_free) begin
            o_status     <= r_cmd.status;
            o_get_data   <= r_gdata;
            o_fill_level <= r_cmd.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rd_v      <= 1'b0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_rd_v <= 1'b0;
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (o_q_pop) begin
                        r_state <= (i_q_cmd.nbytes == '0) ? S_FIN : S_XFER;
                    end
                end
                S_XFER: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (is_put) begin
                        r_wr_idx <= n_idx;
                    end else begin
                        r_rd_idx <= n_idx;
                        r_rd_v   <= 1'b1;
                    end
                    if ((r_cnt + 1'b1) == r_cmd.nbytes) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // wait for the last read byte to land
                    if (!r_rd_v && out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_clear) begin
                r_wr_idx <= '0;
                r_rd_idx <= '0;
            end
        end
    end

endmodule

// ===== hw/rtl/byte_ring_queue_multibyte.sv =====
// Top level of the multi-byte circular byte queue.
// Depends on brq_pkg, brq_front, brq_cmd_fifo and brq_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries put or get requests of
//   0..MAX_ELEMENT_BYTES bytes; output channel (o_out_valid / i_out_stall)
//   returns one result per request, in order: status, get data, fill level.
//   A put that would leave no free slot answers full; a get for more bytes
//   than stored answers empty with 0xFF in the low byte. Neither changes state.
//   The user writes capacity via i_cfg_we / i_cfg_wdata only while idle; the
//   block does not enforce it. Clamped to 2..STORE_DEPTH; a write empties the queue.
// Timing:
//   The front classifies a request in its accept cycle and queues it; the back
//   end moves one byte per cycle through the single-port byte store. A request
//   is popped in S_IDLE, moves its bytes in S_XFER and is answered from S_FIN
//   (a get first waits for its last read byte); refused or empty ones skip S_XFER.
//   The two-entry queue plus the output register let the front keep accepting
//   while a result waits on i_out_stall; o_in_stall rises when the queue is full.
// Reset: synchronous, active low; empties the queue, capacity back to 256
//   (or STORE_DEPTH if smaller). Stored bytes are not cleared.
module byte_ring_queue_multibyte
    import brq_pkg::*;
#(
    parameter int STORE_DEPTH       = DEF_STORE_DEPTH,
    parameter int MAX_ELEMENT_BYTES = DEF_MAX_ELEM
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [NB_W-1:0]    i_element_bytes,
    input  logic [DATA_W-1:0]  i_put_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [DATA_W-1:0]  o_get_data,
    output logic [LEVEL_W-1:0] o_fill_level
);

    localparam int          CAP_RESET = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;
    localparam logic [31:0] SD32      = 32'(STORE_DEPTH);

    logic [CAP_W-1:0] r_capacity;
    logic [CAP_W-1:0] n_capacity;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    t_cmd             q_in_cmd;
    t_cmd             q_out_cmd;

    always_comb begin
        if (i_cfg_wdata < CAP_W'(2)) begin
            n_capacity = CAP_W'(2);
        end else if (32'(i_cfg_wdata) > SD32) begin
            n_capacity = SD32[CAP_W-1:0];
        end else begin
            n_capacity = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(CAP_RESET);
        end else if (i_cfg_we) begin
            r_capacity <= n_capacity;
        end
    end

    brq_front #(
        .MAX_ELEMENT_BYTES(MAX_ELEMENT_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_clear    (i_cfg_we),
        .i_capacity     (r_capacity),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_element_bytes(i_element_bytes),
        .i_put_data     (i_put_data),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in_cmd)
    );

    brq_cmd_fifo u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_cmd  (q_out_cmd),
        .o_empty(q_empty)
    );

    brq_back #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_clear (i_cfg_we),
        .i_capacity  (r_capacity),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_get_data  (o_get_data),
        .o_fill_level(o_fill_level)
    );

endmodule

// ===== hw/rtl/brq_checker.sv =====
// Port-level checks for the byte ring queue, bound to the top level.
// Depends on brq_pkg and byte_ring_queue_multibyte_assert.svh.
`include "byte_ring_queue_multibyte_assert.svh"

module brq_checker
    import brq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [STAT_W-1:0]  o_status,
    input logic [DATA_W-1:0]  o_get_data,
    input logic [LEVEL_W-1:0] o_fill_level
);

    `BRQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

    `BRQ_ASSERT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_get_data) && $stable(o_fill_level))

    `BRQ_ASSERT(a_empty_mark, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY) |-> o_get_data == EMPTY_MARK)

    `BRQ_ASSERT(a_full_no_data, i_clk, i_rst_n, o_out_valid && (o_status == ST_FULL) |-> o_get_data == '0)

    `BRQ_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> (o_status == ST_OK) || (o_status == ST_FULL) || (o_status == ST_EMPTY))

endmodule

bind byte_ring_queue_multibyte brq_checker u_brq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_get_data  (o_get_data),
    .o_fill_level(o_fill_level)
);
